@@ rtl/assert_macros.svh @@
// Concurrent assertion wrappers for the pin edge counter table.
// ASSERT_CLKD checks only while reset is low; ASSERT_ANY checks at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLKD(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define ASSERT_ANY(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_ANY(lbl, clk_s, prop, msg)
`endif
`endif

@@ rtl/pect_pkg.sv @@
`timescale 1ns / 1ps
package pect_pkg;

  localparam int SLOTS    = 8;
  localparam int FUNC_W   = 3;
  localparam int PIN_W    = 8;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_ACTIVATE = 3'd0;
  localparam logic [FUNC_W-1:0] OP_RELEASE  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_READ     = 3'd2;
  localparam logic [FUNC_W-1:0] OP_ZERO     = 3'd3;
  localparam logic [FUNC_W-1:0] OP_EDGE     = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUND   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNBOUND = 2'd3;

  typedef logic [SLOTS-1:0]   slot_vec_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [PIN_W-1:0]   pin_t;

endpackage

@@ rtl/pect_in_if.sv @@
`timescale 1ns / 1ps
interface pect_in_if import pect_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PIN_W-1:0]  pin;

  modport source (output valid, output func, output pin, input ready);
  modport sink   (input valid, input func, input pin, output ready);
endinterface

@@ rtl/pect_out_if.sv @@
`timescale 1ns / 1ps
interface pect_out_if import pect_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output count, output status, input ready);
  modport sink   (input valid, input count, input status, output ready);
endinterface

@@ rtl/pin_edge_counter_table_core.sv @@
`timescale 1ns / 1ps
// Pin edge counter table: SLOTS 32-bit counters, each bound to a pin number.
//
// Channels: cmd carries one command per transaction (func, pin); rsp returns
// exactly one result per command (count, status), in command order.
// Commands: activate binds the pin to the lowest free slot, release frees it,
// read returns its count, zero clears it, edge adds one (wrapping).
//
// A command taken on cmd is held in the input register, is resolved against
// the slot table combinationally, and its result is loaded into the result
// register, which drives rsp. Throughput: one command per cycle while rsp is
// not held off. The parallel pin match over all slots and the single table
// update both fit between the input and result registers, so back-to-back
// edges on the same pin count correctly.
//
// Stall: while rsp is held off, the result register keeps its transaction and
// one more command waits in the input register; cmd.ready then drops.
// Reset (rst, synchronous): frees every slot and empties both registers.
`include "assert_macros.svh"
module pin_edge_counter_table_core import pect_pkg::*; (
  input  logic clk,
  input  logic rst,
  pect_in_if.sink   cmd,
  pect_out_if.source rsp
);

  // Input register
  logic              hold_valid;
  logic [FUNC_W-1:0] hold_func;
  pin_t              hold_pin;

  // Slot table: used bits reset, pins and counts are written on bind
  slot_vec_t used;
  pin_t      slot_pin   [SLOTS];
  count_t    slot_count [SLOTS];

  // Result register
  logic                res_valid;
  count_t              res_count;
  logic [STATUS_W-1:0] res_status;

  logic                advance;
  slot_vec_t           hit;
  slot_vec_t           free_vec;
  slot_vec_t           free_one;
  slot_vec_t           bind_vec;
  slot_vec_t           drop_vec;
  slot_vec_t           clear_vec;
  slot_vec_t           inc_vec;
  count_t              hit_count;
  count_t              count_next;
  logic [STATUS_W-1:0] status_next;

  // Move the held command into the result register whenever that register
  // is empty or being drained this cycle.
  assign advance   = hold_valid && (!res_valid || rsp.ready);
  assign cmd.ready = !hold_valid || advance;

  assign rsp.valid  = res_valid;
  assign rsp.count  = res_count;
  assign rsp.status = res_status;

  // Parallel pin match; activate never allows duplicates, so at most one hit.
  always_comb begin
    hit_count = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = used[i] && (slot_pin[i] == hold_pin);
      if (hit[i]) begin
        hit_count = hit_count | slot_count[i];
      end
    end
  end

  // Lowest free slot as a one-hot vector
  assign free_vec = ~used;
  assign free_one = free_vec & (~free_vec + slot_vec_t'(1));

  // Decode the held command into per-slot actions and a result
  always_comb begin
    bind_vec    = '0;
    drop_vec    = '0;
    clear_vec   = '0;
    inc_vec     = '0;
    count_next  = '0;
    status_next = ST_OK;
    unique case (hold_func)
      OP_ACTIVATE: begin
        if (|hit) begin
          status_next = ST_BOUND;
        end else if (!(|free_vec)) begin
          status_next = ST_FULL;
        end else begin
          bind_vec = free_one;
        end
      end
      OP_RELEASE: begin
        if (!(|hit)) begin
          status_next = ST_UNBOUND;
        end else begin
          drop_vec = hit;
        end
      end
      OP_READ: begin
        if (!(|hit)) begin
          status_next = ST_UNBOUND;
        end else begin
          count_next = hit_count;
        end
      end
      OP_ZERO: begin
        if (!(|hit)) begin
          status_next = ST_UNBOUND;
        end else begin
          clear_vec = hit;
        end
      end
      OP_EDGE: begin
        if (!(|hit)) begin
          status_next = ST_UNBOUND;
        end else begin
          inc_vec = hit;
        end
      end
      default: begin
        // Unused codes: no table change, zero count, ok status
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.ready) begin
      hold_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      hold_func <= cmd.func;
      hold_pin  <= cmd.pin;
    end
  end

  // Slot table update. Counts need no reset: a slot's count is cleared when
  // it is bound and is read only while the slot is used.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (advance) begin
      used <= (used | bind_vec) & ~drop_vec;
    end
    if (advance) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (bind_vec[i]) begin
          slot_pin[i] <= hold_pin;
        end
        if (bind_vec[i] || drop_vec[i] || clear_vec[i]) begin
          slot_count[i] <= '0;
        end else if (inc_vec[i]) begin
          slot_count[i] <= slot_count[i] + count_t'(1);
        end
      end
    end
  end

  // Result register: load on advance, drop once the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      res_count  <= count_next;
      res_status <= status_next;
    end
  end

  `ASSERT_CLKD(a_single_match, clk, rst, $onehot0(hit), "pin bound to more than one slot")
  `ASSERT_ANY(a_reset_frees, clk, rst |=> (used == '0), "slots not freed by reset")
  `ASSERT_CLKD(a_advance_loads, clk, rst, advance |=> res_valid, "advanced command lost")
  `ASSERT_CLKD(a_ready_stall, clk, rst,
    !cmd.ready |-> (hold_valid && res_valid && !rsp.ready), "cmd stalled without cause")
  `ASSERT_CLKD(a_bind_grows, clk, rst,
    (advance && hold_func == OP_ACTIVATE && status_next == ST_OK)
      |=> ($countones(used) == $past($countones(used)) + 1), "activate did not bind a slot")

endmodule

@@ tb/sv/pect_checker.sv @@
`timescale 1ns / 1ps
module pect_checker import pect_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_ready,
  input  logic [FUNC_W-1:0]   cmd_func,
  input  pin_t                cmd_pin,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  count_t              rsp_count,
  input  logic [STATUS_W-1:0] rsp_status,
  output int                  errors,
  output int                  outstanding
);

  typedef struct packed {
    count_t              count;
    logic [STATUS_W-1:0] status;
  } result_t;

  slot_vec_t taken;
  pin_t      taken_pin [SLOTS];
  count_t    tally     [SLOTS];
  result_t   pending_results [$];
  int        mismatches = 0;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  // Apply one command to the shadow table and return the result it should give.
  function automatic result_t resolve_command(input logic [FUNC_W-1:0] op, input pin_t p);
    result_t r;
    int      hit;
    int      free_slot;
    r         = '{count: '0, status: ST_OK};
    hit       = SLOTS;
    free_slot = SLOTS;
    // scan downward so the lowest matching or free slot wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (taken[i] && taken_pin[i] == p) hit = i;
      if (!taken[i]) free_slot = i;
    end
    case (op)
      OP_ACTIVATE: begin
        if (hit < SLOTS) r.status = ST_BOUND;
        else if (free_slot == SLOTS) r.status = ST_FULL;
        else begin
          taken[free_slot]     = 1'b1;
          taken_pin[free_slot] = p;
          tally[free_slot]     = '0;
        end
      end
      OP_RELEASE: begin
        if (hit == SLOTS) r.status = ST_UNBOUND;
        else begin
          taken[hit] = 1'b0;
          tally[hit] = '0;
        end
      end
      OP_READ: begin
        if (hit == SLOTS) r.status = ST_UNBOUND;
        else r.count = tally[hit];
      end
      OP_ZERO: begin
        if (hit == SLOTS) r.status = ST_UNBOUND;
        else tally[hit] = '0;
      end
      OP_EDGE: begin
        if (hit == SLOTS) r.status = ST_UNBOUND;
        else tally[hit] = tally[hit] + 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      taken = '0;
      for (int i = 0; i < SLOTS; i++) begin
        taken_pin[i] = '0;
        tally[i]     = '0;
      end
      pending_results.delete();
    end else begin
      if (cmd_valid && cmd_ready)
        pending_results.push_back(resolve_command(cmd_func, cmd_pin));
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: response with no command pending: count=%0d status=%0d",
                     $time, rsp_count, rsp_status);
        end else begin
          want = pending_results.pop_front();
          if (want.count !== rsp_count || want.status !== rsp_status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected count=%0d status=%0d, got count=%0d status=%0d",
                       $time, want.count, want.status, rsp_count, rsp_status);
          end
        end
      end
    end
    errors      <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import pect_pkg::*;

  localparam int                TARGET_ITEMS = 850;
  localparam int                CYCLE_LIMIT  = 500000;
  // highest operation encoding; everything above OP_EDGE is unused
  localparam logic [FUNC_W-1:0] OP_LAST      = '1;

  logic clk;
  logic rst;
  logic steady;        // when set, neither side inserts gaps
  int   cycles = 0;
  int   issued = 0;    // accepted commands that the block acts on
  int   errors;
  int   outstanding;
  int   stall_left = 0;
  int   roll;

  pect_in_if  cmd_if ();
  pect_out_if rsp_if ();

  pin_edge_counter_table_core u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  // Watch both channels, predict every result and compare it.
  pect_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_if.valid),
    .cmd_ready   (cmd_if.ready),
    .cmd_func    (cmd_if.func),
    .cmd_pin     (cmd_if.pin),
    .rsp_valid   (rsp_if.valid),
    .rsp_ready   (rsp_if.ready),
    .rsp_count   (rsp_if.count),
    .rsp_status  (rsp_if.status),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Gap length shared by both sides: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Back-pressure on the result channel. Hold ready low for the drawn stall
  // length, then release it; in steady stretches keep it high throughout.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      roll = steady ? 0 : pick_gap();
      if (roll > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left   <= roll - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Offer one command, optionally after an idle gap, and hold it until the
  // block takes the transaction. Valid stays high into the next command when
  // there is no gap, so it is never lowered and raised in the same step.
  task automatic send_cmd(input logic [FUNC_W-1:0] op, input pin_t p);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.func  <= op;
    cmd_if.pin   <= p;
    do @(posedge clk); while (!cmd_if.ready);
    if (op <= OP_EDGE) issued++;
  endtask

  // One random phase: bind a small pool of pins, hammer it with a mix that is
  // mostly edges with reads, zeros and re-binds in between, sprinkle in stray
  // pins and unused codes, then release the pool so the next phase finds
  // free slots. Pools larger than the table exercise the full case.
  task automatic run_phase(input int length);
    pin_t              pool [12];
    int                pool_n;
    int                r;
    pin_t              p;
    logic [FUNC_W-1:0] op;
    pool_n = $urandom_range(3, 12);
    for (int i = 0; i < pool_n; i++) pool[i] = pin_t'($urandom_range(0, 255));
    for (int i = 0; i < pool_n; i++) send_cmd(OP_ACTIVATE, pool[i]);
    for (int n = 0; n < length; n++) begin
      if ($urandom_range(0, 9) == 0) p = pin_t'($urandom_range(0, 255));
      else p = pool[$urandom_range(0, pool_n - 1)];
      r = $urandom_range(0, 99);
      if (r < 8) op = OP_ACTIVATE;
      else if (r < 14) op = OP_RELEASE;
      else if (r < 26) op = OP_READ;
      else if (r < 31) op = OP_ZERO;
      else if (r < 33) op = FUNC_W'($urandom_range(OP_EDGE + 1, OP_LAST));
      else op = OP_EDGE;
      send_cmd(op, p);
    end
    for (int i = 0; i < pool_n; i++) send_cmd(OP_RELEASE, pool[i]);
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst          = 1'b1;
    steady       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.func  = OP_READ;
    cmd_if.pin   = '0;
    rsp_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: read, release, zero and edge against an empty table first.
    send_cmd(OP_READ,    8'h00);
    send_cmd(OP_RELEASE, 8'hFF);
    send_cmd(OP_ZERO,    8'h5A);
    send_cmd(OP_EDGE,    8'h00);
    // Bind both extreme pins, then try a duplicate bind.
    send_cmd(OP_ACTIVATE, 8'h00);
    send_cmd(OP_ACTIVATE, 8'hFF);
    send_cmd(OP_ACTIVATE, 8'h00);
    // Count, read back, clear, read again.
    send_cmd(OP_EDGE,  8'h00);
    send_cmd(OP_EDGE,  8'h00);
    send_cmd(OP_READ,  8'h00);
    send_cmd(OP_ZERO,  8'h00);
    send_cmd(OP_READ,  8'h00);
    // Fill the remaining slots, then bind one more with no room left.
    for (int i = 0; i < 6; i++) send_cmd(OP_ACTIVATE, pin_t'(1 << i));
    send_cmd(OP_ACTIVATE, 8'h80);
    // Free a slot with a live count; a new pin takes it with a cleared count.
    send_cmd(OP_EDGE,     8'hFF);
    send_cmd(OP_RELEASE,  8'hFF);
    send_cmd(OP_ACTIVATE, 8'h80);
    send_cmd(OP_READ,     8'h80);
    // Unused encodings must be ignored.
    send_cmd(OP_EDGE + 3'd1, 8'hAA);
    send_cmd(OP_EDGE + 3'd2, 8'h55);
    send_cmd(OP_EDGE + 3'd3, 8'h00);
    // Empty the table before the random part.
    send_cmd(OP_RELEASE, 8'h00);
    for (int i = 0; i < 6; i++) send_cmd(OP_RELEASE, pin_t'(1 << i));
    send_cmd(OP_RELEASE, 8'h80);
    // The wrap of a 32-bit counter lies beyond any run here.

    // Random phases; about one in five runs with no gaps on either side.
    while (issued < TARGET_ITEMS) begin
      steady <= ($urandom_range(0, 4) == 0);
      run_phase($urandom_range(40, 120));
    end

    // Drain: drop valid, wait for every expected result, then settle.
    cmd_if.valid <= 1'b0;
    steady       <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
